/* src/mmp_pkg.sv */
// Minimap point projector package: widths, register indexes, colour codes
// and the structs that travel between the pipeline modules.
// No dependencies.
`default_nettype none

package mmp_pkg;

    // Fixed-point formats
    localparam int COORD_FRAC_BITS = 4;
    localparam int TRIG_FRAC_BITS  = 14;

    // Field widths
    localparam int POS_W   = 20;                          // world coordinate
    localparam int TRIG_W  = 16;                          // Q2.14 sine / cosine
    localparam int SIZE_W  = 10;                          // radar size, pixels
    localparam int VD_W    = 15;                          // view distance
    localparam int SLOT_W  = 10;                          // slot number
    localparam int CFG_W   = 20;                          // config write data
    localparam int IDX_W   = 3;                           // config register index

    // Datapath widths
    localparam int DIFF_W  = POS_W + 1;                   // object minus center
    localparam int PROD_W  = DIFF_W + TRIG_W;             // one rotation product
    localparam int SUM_W   = PROD_W + 1;                  // sum of two products
    localparam int ROT_W   = SUM_W - TRIG_FRAC_BITS;      // rotated offset
    localparam int DBL_W   = ROT_W + 1;                   // doubled offset magnitude
    localparam int SQ_W    = 2 * DBL_W;                   // sum of squares
    localparam int ROOT_W  = DBL_W;                       // square root result
    localparam int D_W     = VD_W + COORD_FRAC_BITS;      // full span D
    localparam int DEN_W   = DBL_W;                       // divisor
    localparam int RXS_W   = ROT_W + SIZE_W + 1;          // offset times size
    localparam int HD_W    = SIZE_W - 1 + DEN_W;          // half size times divisor
    localparam int NUM_W   = HD_W + 3;                    // signed numerator
    localparam int Q_W     = SIZE_W + 1;                  // quotient bits

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SHAPE_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_RADAR_SIZE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_VIEW_DISTANCE = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEADING_COS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_HEADING_SIN   = 3'd4;
    localparam logic [IDX_W-1:0] REG_CENTER_X      = 3'd5;
    localparam logic [IDX_W-1:0] REG_CENTER_Y      = 3'd6;

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_RADAR_SIZE    = 10'd250;
    localparam logic [VD_W-1:0]   RST_VIEW_DISTANCE = 15'd2048;
    localparam logic [TRIG_W-1:0] RST_HEADING_COS   = 16'd0;
    localparam logic [TRIG_W-1:0] RST_HEADING_SIN   = 16'd16384;

    // Shape modes
    localparam logic SHAPE_ROUND  = 1'b0;
    localparam logic SHAPE_SQUARE = 1'b1;

    typedef enum logic [1:0] {
        COL_FRIEND  = 2'd0,
        COL_ENEMY   = 2'd1,
        COL_NEUTRAL = 2'd2,
        COL_ITEM    = 2'd3
    } t_colour;

    // Pass-through part of a request
    typedef struct packed {
        t_colour             colour;
        logic                player;
        logic [SLOT_W-1:0]   slot;
    } t_side;

    // Rotation setup
    typedef struct packed {
        logic signed [TRIG_W-1:0] heading_cos;
        logic signed [TRIG_W-1:0] heading_sin;
        logic signed [POS_W-1:0]  center_x;
        logic signed [POS_W-1:0]  center_y;
    } t_rot_cfg;

    // Payload carried down the square root pipeline
    typedef struct packed {
        logic signed [RXS_W-1:0] rxs;
        logic signed [RXS_W-1:0] rys;
        logic [DEN_W-1:0]        alt;
        logic                    need;
        t_side                   side;
    } t_clamp_pay;

    // Colour class by flag priority
    function automatic t_colour colour_of(input logic item, input logic enemy,
                                          input logic neutral);
        t_colour c;
        if (item) begin
            c = enemy ? COL_ENEMY : (neutral ? COL_NEUTRAL : COL_ITEM);
        end else begin
            c = neutral ? COL_NEUTRAL : (enemy ? COL_ENEMY : COL_FRIEND);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/mmp_obj_if.sv */
// Object request channel: valid/ready handshake with the object payload.
// Depends on mmp_pkg for field widths.
`default_nettype none

interface mmp_obj_if
    import mmp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] object_x;
    logic signed [POS_W-1:0] object_y;
    logic                    object_valid;
    logic                    flag_item;
    logic                    flag_enemy;
    logic                    flag_neutral;
    logic                    flag_player;
    logic [SLOT_W-1:0]       object_index;

    modport source (
        output valid, object_x, object_y, object_valid, flag_item, flag_enemy,
               flag_neutral, flag_player, object_index,
        input  ready
    );
    modport sink (
        input  valid, object_x, object_y, object_valid, flag_item, flag_enemy,
               flag_neutral, flag_player, object_index,
        output ready
    );
endinterface

`default_nettype wire

/* src/mmp_pix_if.sv */
// Pixel result channel: valid/ready handshake with the radar pixel payload.
// Depends on mmp_pkg for field widths.
`default_nettype none

interface mmp_pix_if
    import mmp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] pixel_x;
    logic [SIZE_W-1:0] pixel_y;
    logic [1:0]        colour_class;
    logic              is_player_out;
    logic [SLOT_W-1:0] slot_out;

    modport source (
        output valid, pixel_x, pixel_y, colour_class, is_player_out, slot_out,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, colour_class, is_player_out, slot_out,
        output ready
    );
endinterface

`default_nettype wire

/* src/minimap_point_projector.sv */
// Minimap point projector top level: configuration registers, stall control
// and the rotate, clamp and project pipelines. Depends on mmp_pkg, mmp_obj_if,
// mmp_pix_if, mmp_rotate, mmp_clamp and mmp_project.
//
// Usage:
//   i_obj carries one object request per valid/ready handshake. Requests with
//   object_valid low are taken and dropped; every other request gives exactly
//   one result on o_pix, in order.
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes one
//   register per cycle; write only while no request is in flight.
// Pipeline and throughput:
//   3 rotation stages, 3 square and compare stages, a 25-stage square root at
//   one root bit per stage, 2 numerator stages, a saturation check and an
//   11-stage divider at one quotient bit per stage, then the output register.
//   One request enters every cycle while the output is not stalled.
// Reset:
//   Synchronous, active low. Clears all valid bits and loads the register
//   defaults (round mode, size 250, view distance 2048, heading 90 degrees).
// Stall:
//   While a result waits on o_pix with ready low, the whole pipeline holds and
//   i_obj.ready is low; empty stages do not stall anything.
`default_nettype none

module minimap_point_projector
    import mmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    mmp_obj_if.sink          i_obj,
    mmp_pix_if.source        o_pix
);

    logic              r_shape_mode;
    logic [SIZE_W-1:0] r_radar_size;
    logic [VD_W-1:0]   r_view_distance;
    t_rot_cfg          r_rot_cfg;

    logic              w_en;
    t_side             w_in_side;

    logic                    w_rot_v;
    logic signed [ROT_W-1:0] w_rx, w_ry;
    t_side                   w_rot_side;

    logic                    w_cl_v;
    logic [DEN_W-1:0]        w_den;
    logic signed [RXS_W-1:0] w_rxs, w_rys;
    t_side                   w_cl_side;

    logic                    w_pj_v;
    logic [SIZE_W-1:0]       w_px, w_py;
    t_side                   w_pj_side;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode          <= SHAPE_ROUND;
            r_radar_size          <= RST_RADAR_SIZE;
            r_view_distance       <= RST_VIEW_DISTANCE;
            r_rot_cfg.heading_cos <= RST_HEADING_COS;
            r_rot_cfg.heading_sin <= RST_HEADING_SIN;
            r_rot_cfg.center_x    <= '0;
            r_rot_cfg.center_y    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHAPE_MODE:    r_shape_mode          <= i_cfg_data[0];
                REG_RADAR_SIZE:    r_radar_size          <= i_cfg_data[SIZE_W-1:0];
                REG_VIEW_DISTANCE: r_view_distance       <= i_cfg_data[VD_W-1:0];
                REG_HEADING_COS:   r_rot_cfg.heading_cos <= i_cfg_data[TRIG_W-1:0];
                REG_HEADING_SIN:   r_rot_cfg.heading_sin <= i_cfg_data[TRIG_W-1:0];
                REG_CENTER_X:      r_rot_cfg.center_x    <= i_cfg_data[POS_W-1:0];
                REG_CENTER_Y:      r_rot_cfg.center_y    <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the pipeline unless a result is held at the output
    assign w_en        = !w_pj_v || o_pix.ready;
    assign i_obj.ready = w_en;

    always_comb begin
        w_in_side.colour = colour_of(i_obj.flag_item, i_obj.flag_enemy, i_obj.flag_neutral);
        w_in_side.player = i_obj.flag_player;
        w_in_side.slot   = i_obj.object_index;
    end

    mmp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_obj.valid && i_obj.object_valid),
        .i_obj_x (i_obj.object_x),
        .i_obj_y (i_obj.object_y),
        .i_side  (w_in_side),
        .i_cfg   (r_rot_cfg),
        .o_valid (w_rot_v),
        .o_rx    (w_rx),
        .o_ry    (w_ry),
        .o_side  (w_rot_side)
    );

    mmp_clamp u_clamp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (w_rot_v),
        .i_rx            (w_rx),
        .i_ry            (w_ry),
        .i_side          (w_rot_side),
        .i_shape_mode    (r_shape_mode),
        .i_radar_size    (r_radar_size),
        .i_view_distance (r_view_distance),
        .o_valid         (w_cl_v),
        .o_den           (w_den),
        .o_rxs           (w_rxs),
        .o_rys           (w_rys),
        .o_side          (w_cl_side)
    );

    mmp_project u_project (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_cl_v),
        .i_den        (w_den),
        .i_rxs        (w_rxs),
        .i_rys        (w_rys),
        .i_side       (w_cl_side),
        .i_radar_size (r_radar_size),
        .o_valid      (w_pj_v),
        .o_pixel_x    (w_px),
        .o_pixel_y    (w_py),
        .o_side       (w_pj_side)
    );

    // Drive the result channel
    assign o_pix.valid         = w_pj_v;
    assign o_pix.pixel_x       = w_px;
    assign o_pix.pixel_y       = w_py;
    assign o_pix.colour_class  = w_pj_side.colour;
    assign o_pix.is_player_out = w_pj_side.player;
    assign o_pix.slot_out      = w_pj_side.slot;

    // A held result must block new requests
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_obj.ready)
        else $error("request taken while a result is held");

    // Reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

/* src/mmp_rotate.sv */
// Three-stage front end: subtract the viewer center, form the four rotation
// products, then sum and scale back to coordinate format. Depends on mmp_pkg.
`default_nettype none

module mmp_rotate
    import mmp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [POS_W-1:0] i_obj_x,
    input  logic signed [POS_W-1:0] i_obj_y,
    input  t_side                   i_side,
    input  t_rot_cfg                i_cfg,
    output logic                    o_valid,
    output logic signed [ROT_W-1:0] o_rx,
    output logic signed [ROT_W-1:0] o_ry,
    output t_side                   o_side
);

    logic [2:0]                r_v;
    t_side                     r_side [0:2];
    logic signed [DIFF_W-1:0]  r_dx, r_dy, n_dx, n_dy;
    logic signed [PROD_W-1:0]  r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [PROD_W-1:0]  n_pxc, n_pys, n_pxs, n_pyc;
    logic signed [SUM_W-1:0]   n_sx, n_sy, n_tx, n_ty;
    logic signed [ROT_W-1:0]   r_rx, r_ry, n_rx, n_ry;

    // Offset from the viewer
    always_comb begin
        n_dx = DIFF_W'(i_obj_x) - DIFF_W'(i_cfg.center_x);
        n_dy = DIFF_W'(i_obj_y) - DIFF_W'(i_cfg.center_y);
    end

    // Rotation products
    always_comb begin
        n_pxc = PROD_W'(r_dx) * PROD_W'(i_cfg.heading_cos);
        n_pys = PROD_W'(r_dy) * PROD_W'(i_cfg.heading_sin);
        n_pxs = PROD_W'(r_dx) * PROD_W'(i_cfg.heading_sin);
        n_pyc = PROD_W'(r_dy) * PROD_W'(i_cfg.heading_cos);
    end

    // Sum and drop trig fraction bits, truncating toward zero
    always_comb begin
        n_sx = SUM_W'(r_pxc) - SUM_W'(r_pys);
        n_sy = SUM_W'(r_pxs) + SUM_W'(r_pyc);
        n_tx = n_sx + $signed({{(SUM_W-TRIG_FRAC_BITS){1'b0}},
                               {TRIG_FRAC_BITS{n_sx[SUM_W-1]}}});
        n_ty = n_sy + $signed({{(SUM_W-TRIG_FRAC_BITS){1'b0}},
                               {TRIG_FRAC_BITS{n_sy[SUM_W-1]}}});
        n_rx = ROT_W'(n_tx >>> TRIG_FRAC_BITS);
        n_ry = ROT_W'(n_ty >>> TRIG_FRAC_BITS);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx      <= n_dx;
            r_dy      <= n_dy;
            r_side[0] <= i_side;
            r_pxc     <= n_pxc;
            r_pys     <= n_pys;
            r_pxs     <= n_pxs;
            r_pyc     <= n_pyc;
            r_side[1] <= r_side[0];
            r_rx      <= n_rx;
            r_ry      <= n_ry;
            r_side[2] <= r_side[1];
        end
    end

    assign o_valid = r_v[2];
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_side  = r_side[2];

endmodule

`default_nettype wire

/* src/mmp_clamp.sv */
// Clamp stage: squares, magnitude and span compares, then a bit-per-stage
// square root pipeline that yields the divisor. Depends on mmp_pkg.
`default_nettype none

module mmp_clamp
    import mmp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ROT_W-1:0] i_rx,
    input  logic signed [ROT_W-1:0] i_ry,
    input  t_side                   i_side,
    input  logic                    i_shape_mode,
    input  logic [SIZE_W-1:0]       i_radar_size,
    input  logic [VD_W-1:0]         i_view_distance,
    output logic                    o_valid,
    output logic [DEN_W-1:0]        o_den,
    output logic signed [RXS_W-1:0] o_rxs,
    output logic signed [RXS_W-1:0] o_rys,
    output t_side                   o_side
);

    logic                    r_v1, r_v2;
    t_side                   r_side1, r_side2;
    logic [DBL_W-1:0]        r_absx, r_absy, n_absx, n_absy;
    logic signed [DBL_W-1:0] n_ax, n_ay;
    logic signed [RXS_W-1:0] r_rxs1, r_rys1, r_rxs2, r_rys2;
    logic [D_W-1:0]          r_d, n_d;
    logic [VD_W-1:0]         n_vd;
    logic [SQ_W-1:0]         r_sqx, r_sqy, r_dsq, n_s;
    logic [DEN_W-1:0]        r_alt, n_alt, n_m;

    // Pipeline of the square root: index 0 is the compare stage output
    logic [SQ_W-1:0]         r_sx [0:ROOT_W];
    logic [SQ_W-1:0]         r_sr [0:ROOT_W];
    t_clamp_pay              r_sp [0:ROOT_W];
    logic [ROOT_W:0]         r_sv;

    // Doubled offsets, magnitudes, span
    always_comb begin
        n_ax   = {i_rx, 1'b0};
        n_ay   = {i_ry, 1'b0};
        n_absx = n_ax[DBL_W-1] ? DBL_W'(-n_ax) : DBL_W'(n_ax);
        n_absy = n_ay[DBL_W-1] ? DBL_W'(-n_ay) : DBL_W'(n_ay);
        n_vd   = (i_view_distance == '0) ? VD_W'(1) : i_view_distance;
        n_d    = {n_vd, {COORD_FRAC_BITS{1'b0}}};
    end

    // Divisor other than the root: the larger magnitude in square mode when it exceeds the span, else the span
    always_comb begin
        n_m   = (r_absx > r_absy) ? r_absx : r_absy;
        n_alt = DEN_W'(r_d);
        if (i_shape_mode == SHAPE_SQUARE && n_m > DEN_W'(r_d)) begin
            n_alt = n_m;
        end
    end

    assign n_s = r_sqx + r_sqy;

    // Front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_sv[0]  <= 1'b0;
        end else if (i_en) begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_sv[0]  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_absx  <= n_absx;
            r_absy  <= n_absy;
            r_rxs1  <= RXS_W'(i_rx) * RXS_W'($signed({1'b0, i_radar_size}));
            r_rys1  <= RXS_W'(i_ry) * RXS_W'($signed({1'b0, i_radar_size}));
            r_d     <= n_d;
            r_side1 <= i_side;

            r_sqx   <= SQ_W'(r_absx) * SQ_W'(r_absx);
            r_sqy   <= SQ_W'(r_absy) * SQ_W'(r_absy);
            r_dsq   <= SQ_W'(r_d) * SQ_W'(r_d);
            r_alt   <= n_alt;
            r_rxs2  <= r_rxs1;
            r_rys2  <= r_rys1;
            r_side2 <= r_side1;

            r_sx[0]      <= n_s;
            r_sr[0]      <= '0;
            r_sp[0].rxs  <= r_rxs2;
            r_sp[0].rys  <= r_rys2;
            r_sp[0].alt  <= r_alt;
            r_sp[0].need <= (i_shape_mode == SHAPE_ROUND) && (n_s > r_dsq);
            r_sp[0].side <= r_side2;
        end
    end

    // One root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int SH = 2 * (ROOT_W - 1 - k);
        logic [SQ_W-1:0] n_bit, n_t;

        assign n_bit = SQ_W'(1) << SH;
        assign n_t   = r_sr[k] + n_bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sp[k+1] <= r_sp[k];
                if (r_sx[k] >= n_t) begin
                    r_sx[k+1] <= r_sx[k] - n_t;
                    r_sr[k+1] <= (r_sr[k] >> 1) + n_bit;
                end else begin
                    r_sx[k+1] <= r_sx[k];
                    r_sr[k+1] <= r_sr[k] >> 1;
                end
            end
        end
    end

    assign o_valid = r_sv[ROOT_W];
    assign o_den   = r_sp[ROOT_W].need ? DEN_W'(r_sr[ROOT_W]) : r_sp[ROOT_W].alt;
    assign o_rxs   = r_sp[ROOT_W].rxs;
    assign o_rys   = r_sp[ROOT_W].rys;
    assign o_side  = r_sp[ROOT_W].side;

endmodule

`default_nettype wire

/* src/mmp_project.sv */
// Projection stage: numerators for both axes, a pipelined restoring divider
// with a quotient bit per stage, saturation and the output register.
// Depends on mmp_pkg.
`default_nettype none

module mmp_project
    import mmp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [DEN_W-1:0]        i_den,
    input  logic signed [RXS_W-1:0] i_rxs,
    input  logic signed [RXS_W-1:0] i_rys,
    input  t_side                   i_side,
    input  logic [SIZE_W-1:0]       i_radar_size,
    output logic                    o_valid,
    output logic [SIZE_W-1:0]       o_pixel_x,
    output logic [SIZE_W-1:0]       o_pixel_y,
    output t_side                   o_side
);

    localparam int STG = Q_W + 2;   // numerator, saturation check, quotient bits

    logic                    r_v1;
    logic [HD_W-1:0]         r_hd;
    logic [DEN_W-1:0]        r_den1;
    logic signed [RXS_W-1:0] r_rxs, r_rys;
    t_side                   r_side1;
    logic signed [NUM_W-1:0] n_num [0:1];

    logic [STG-1:0]          r_dv;
    logic [DEN_W-1:0]        r_dd   [0:STG-1];
    t_side                   r_ds   [0:STG-1];
    logic [NUM_W-2:0]        r_rem  [0:STG-1][0:1];
    logic [Q_W-1:0]          r_q    [0:STG-1][0:1];
    logic                    r_neg  [0:STG-1][0:1];
    logic                    r_sat  [0:STG-1][0:1];

    logic                    r_ov;
    logic [SIZE_W-1:0]       r_px, r_py;
    t_side                   r_os;
    logic [SIZE_W-1:0]       n_pix [0:1];

    // Signed numerators
    always_comb begin
        n_num[0] = NUM_W'(r_rxs) + NUM_W'($signed({1'b0, r_hd}));
        n_num[1] = NUM_W'($signed({1'b0, r_hd})) - NUM_W'(r_rys);
    end

    // Valid bits of the numerator and divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_dv <= {r_dv[STG-2:0], r_v1};
            r_ov <= r_dv[STG-1];
        end
    end

    // Half size times divisor, then numerators
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hd    <= HD_W'(i_radar_size[SIZE_W-1:1]) * HD_W'(i_den);
            r_den1  <= i_den;
            r_rxs   <= i_rxs;
            r_rys   <= i_rys;
            r_side1 <= i_side;

            r_dd[0] <= r_den1;
            r_ds[0] <= r_side1;
            for (int a = 0; a < 2; a++) begin
                r_rem[0][a] <= n_num[a][NUM_W-2:0];
                r_neg[0][a] <= n_num[a][NUM_W-1];
                r_q[0][a]   <= '0;
                r_sat[0][a] <= 1'b0;
            end
        end
    end

    // Flag quotients that would not fit in the quotient bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dd[1] <= r_dd[0];
            r_ds[1] <= r_ds[0];
            for (int a = 0; a < 2; a++) begin
                r_rem[1][a] <= r_rem[0][a];
                r_neg[1][a] <= r_neg[0][a];
                r_q[1][a]   <= '0;
                r_sat[1][a] <= r_rem[0][a] >= ((NUM_W-1)'(r_dd[0]) << Q_W);
            end
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 2; k < STG; k++) begin : g_div
        localparam int B = STG - 1 - k;
        logic [NUM_W-2:0] n_sub;

        assign n_sub = (NUM_W-1)'(r_dd[k-1]) << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd[k] <= r_dd[k-1];
                r_ds[k] <= r_ds[k-1];
                for (int a = 0; a < 2; a++) begin
                    r_neg[k][a] <= r_neg[k-1][a];
                    r_sat[k][a] <= r_sat[k-1][a];
                    if (r_rem[k-1][a] >= n_sub) begin
                        r_rem[k][a] <= r_rem[k-1][a] - n_sub;
                        r_q[k][a]   <= r_q[k-1][a] | (Q_W'(1) << B);
                    end else begin
                        r_rem[k][a] <= r_rem[k-1][a];
                        r_q[k][a]   <= r_q[k-1][a];
                    end
                end
            end
        end
    end

    // Clip to 0..size
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (r_neg[STG-1][a]) begin
                n_pix[a] = '0;
            end else if (r_sat[STG-1][a] || r_q[STG-1][a] > Q_W'(i_radar_size)) begin
                n_pix[a] = i_radar_size;
            end else begin
                n_pix[a] = r_q[STG-1][a][SIZE_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_pix[0];
            r_py <= n_pix[1];
            r_os <= r_ds[STG-1];
        end
    end

    assign o_valid   = r_ov;
    assign o_pixel_x = r_px;
    assign o_pixel_y = r_py;
    assign o_side    = r_os;

endmodule

`default_nettype wire

/* verif/minimap_point_projector_test.sv */
// Testbench for the minimap point projector: random and directed object
// requests, an exact integer projection predictor and a scoreboard class.
// Depends on mmp_pkg, mmp_obj_if, mmp_pix_if and minimap_point_projector.
`timescale 1ns / 1ps

module minimap_point_projector_test;
    import mmp_pkg::*;

    localparam int LATENCY   = 46;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [SIZE_W-1:0] px;
        logic [SIZE_W-1:0] py;
        t_colour           colour;
        logic              player;
        logic [SLOT_W-1:0] slot;
    } t_pixel;

    // projection settings held by the predictor
    logic                     cfg_shape;
    logic [SIZE_W-1:0]        cfg_size;
    logic [VD_W-1:0]          cfg_vd;
    logic signed [TRIG_W-1:0] cfg_cos;
    logic signed [TRIG_W-1:0] cfg_sin;
    logic signed [POS_W-1:0]  cfg_cx;
    logic signed [POS_W-1:0]  cfg_cy;

    int unsigned n_errors;

    task automatic report(input string what, input int got, input int want);
        n_errors++;
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] to_pixel(input longint num, input longint den);
        longint q;
        if (num < 0) return '0;
        q = num / den;
        return (q > cfg_size) ? cfg_size : q[SIZE_W-1:0];
    endfunction

    // project one object to radar pixels
    function automatic t_pixel project_object(input logic signed [POS_W-1:0] ox,
                                              input logic signed [POS_W-1:0] oy,
                                              input logic it, input logic en,
                                              input logic ne, input logic pl,
                                              input logic [SLOT_W-1:0] slot);
        longint dx, dy, rx, ry, ax, ay, span, den, half, sz, m;
        longint unsigned s;
        t_pixel r;
        dx = longint'(ox) - longint'(cfg_cx);
        dy = longint'(oy) - longint'(cfg_cy);
        rx = (dx * cfg_cos - dy * cfg_sin) / 16384;
        ry = (dx * cfg_sin + dy * cfg_cos) / 16384;
        ax = 2 * rx;
        ay = 2 * ry;
        span = longint'((cfg_vd == 0) ? 1 : cfg_vd) << COORD_FRAC_BITS;
        den = span;
        if (cfg_shape == SHAPE_ROUND) begin
            s = ax * ax + ay * ay;
            if (s > span * span) den = int_sqrt(s);
        end else begin
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            m = (ax > ay) ? ax : ay;
            if (m > span) den = m;
        end
        sz = cfg_size;
        half = sz / 2;
        r.px = to_pixel(rx * sz + half * den, den);
        r.py = to_pixel(-ry * sz + half * den, den);
        if (it) r.colour = en ? COL_ENEMY : (ne ? COL_NEUTRAL : COL_ITEM);
        else r.colour = ne ? COL_NEUTRAL : (en ? COL_ENEMY : COL_FRIEND);
        r.player = pl;
        r.slot = slot;
        return r;
    endfunction

    class pixel_board;
        t_pixel pending[$];
        int unsigned n_checked;

        function void note(input t_pixel p);
            pending.push_back(p);
        endfunction

        task check(input t_pixel got);
            t_pixel want;
            if (pending.size() == 0) begin
                report("unexpected result", got.slot, -1);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.px !== want.px) report("pixel_x", got.px, want.px);
            if (got.py !== want.py) report("pixel_y", got.py, want.py);
            if (got.colour !== want.colour) report("colour_class", got.colour, want.colour);
            if (got.player !== want.player) report("is_player_out", got.player, want.player);
            if (got.slot !== want.slot) report("slot_out", got.slot, want.slot);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    mmp_obj_if obj_ch();
    mmp_pix_if pix_ch();

    minimap_point_projector i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_obj(obj_ch.sink), .o_pix(pix_ch.source)
    );

    always #1 i_clk = ~i_clk;

    pixel_board board = new();
    int unsigned idle_pct = 12;
    int unsigned hold_off = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_requests = 0;

    initial begin
        obj_ch.valid = 0;
        obj_ch.object_x = '0;
        obj_ch.object_y = '0;
        obj_ch.object_valid = 0;
        obj_ch.flag_item = 0;
        obj_ch.flag_enemy = 0;
        obj_ch.flag_neutral = 0;
        obj_ch.flag_player = 0;
        obj_ch.object_index = '0;
        pix_ch.ready = 0;
    end

    // sample results and count quiet cycles
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            got.px = pix_ch.pixel_x;
            got.py = pix_ch.pixel_y;
            got.colour = t_colour'(pix_ch.colour_class);
            got.player = pix_ch.is_player_out;
            got.slot = pix_ch.slot_out;
            board.check(got);
        end
        if ((pix_ch.valid && pix_ch.ready) || (obj_ch.valid && obj_ch.ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog expired, %0d results pending", board.pending.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            pix_ch.ready <= 1'b0;
        end else begin
            pix_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_SHAPE_MODE:    cfg_shape = data[0];
            REG_RADAR_SIZE:    cfg_size = data[SIZE_W-1:0];
            REG_VIEW_DISTANCE: cfg_vd = data[VD_W-1:0];
            REG_HEADING_COS:   cfg_cos = data[TRIG_W-1:0];
            REG_HEADING_SIN:   cfg_sin = data[TRIG_W-1:0];
            REG_CENTER_X:      cfg_cx = data[POS_W-1:0];
            REG_CENTER_Y:      cfg_cy = data[POS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one request and hold it until taken; valid stays high for the next
    task automatic send_object(input logic signed [POS_W-1:0] ox,
                               input logic signed [POS_W-1:0] oy,
                               input logic ov, input logic [3:0] flags,
                               input logic [SLOT_W-1:0] slot);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            obj_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        obj_ch.valid <= 1'b1;
        obj_ch.object_x <= ox;
        obj_ch.object_y <= oy;
        obj_ch.object_valid <= ov;
        obj_ch.flag_item <= flags[0];
        obj_ch.flag_enemy <= flags[1];
        obj_ch.flag_neutral <= flags[2];
        obj_ch.flag_player <= flags[3];
        obj_ch.object_index <= slot;
        @(posedge i_clk);
        while (!obj_ch.ready) @(posedge i_clk);
        if (ov) board.note(project_object(ox, oy, flags[0], flags[1], flags[2],
                                          flags[3], slot));
        n_requests++;
    endtask

    // drop valid, then wait for the pipeline to drain before touching registers
    task automatic drain();
        @(negedge i_clk);
        obj_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // random coordinate: mostly near the center, sometimes full range
    function automatic logic [POS_W-1:0] rand_pos(input logic [POS_W-1:0] c);
        int unsigned k;
        k = $urandom_range(3);
        if (k == 0) return $urandom();
        return c + $signed($urandom_range(0, 1 << (8 + 3 * k)) - (1 << (7 + 3 * k)));
    endfunction

    task automatic random_phase(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_object(rand_pos(cfg_cx), rand_pos(cfg_cy), ($urandom_range(9) != 0),
                        $urandom(), $urandom());
        end
    endtask

    initial begin
        cfg_shape = SHAPE_ROUND;
        cfg_size = RST_RADAR_SIZE;
        cfg_vd = RST_VIEW_DISTANCE;
        cfg_cos = RST_HEADING_COS;
        cfg_sin = RST_HEADING_SIN;
        cfg_cx = '0;
        cfg_cy = '0;
        n_errors = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extremes, every colour combination
        send_object(20'sh7FFFF, 20'sh7FFFF, 1, 4'b0000, 10'd0);
        send_object(20'sh80000, 20'sh80000, 1, 4'b1111, 10'd1023);
        send_object(20'sh80000, 20'sh7FFFF, 0, 4'b0001, 10'd5);
        send_object(0, 0, 1, 4'b0001, 10'd1);
        for (int f = 0; f < 16; f++)
            send_object(f * 64, -f * 100, 1, f[3:0], f[9:0]);
        drain();
        write_reg(REG_SHAPE_MODE, SHAPE_SQUARE);
        write_reg(REG_RADAR_SIZE, 0);
        write_reg(REG_VIEW_DISTANCE, 0);
        write_reg(REG_HEADING_COS, 20'h04000);
        write_reg(REG_HEADING_SIN, 20'h0);
        write_reg(3'd7, 20'hFFFFF);
        send_object(20'sh7FFFF, 20'sh80000, 1, 4'b0010, 10'd77);
        send_object(16, -16, 1, 4'b0100, 10'd78);
        drain();

        // random phases over several settings, extremes included
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_SHAPE_MODE, ph[0]);
            write_reg(REG_RADAR_SIZE, (ph == 1) ? 1000 : (ph == 2) ? 1 : $urandom_range(1, 1000));
            write_reg(REG_VIEW_DISTANCE,
                      (ph == 3) ? 16384 : (ph == 4) ? 1 : $urandom_range(1, 4000));
            write_reg(REG_HEADING_COS,
                      (ph == 5) ? 20'hFC000 : (ph == 6) ? 20'h0FFFF : $urandom_range(0, 32768) - 16384);
            write_reg(REG_HEADING_SIN,
                      (ph == 5) ? 20'h04000 : (ph == 6) ? 20'h08000 : $urandom_range(0, 32768) - 16384);
            write_reg(REG_CENTER_X, (ph == 7) ? 20'h80000 : (ph == 8) ? 20'h7FFFF : $urandom());
            write_reg(REG_CENTER_Y, (ph == 7) ? 20'h7FFFF : (ph == 8) ? 20'h80000 : $urandom());
            idle_pct = (ph == 4) ? 0 : 12;
            if (ph == 2) begin
                fork
                    hold_off = 300;
                    random_phase(150);
                join
            end else begin
                random_phase(150);
            end
            drain();
        end

        $display("Sent %0d object requests over 12 register settings, checked %0d results.",
                 n_requests, board.n_checked);
        $display("Covered round and square clamps, size and span extremes, long output stall.");
        if (n_errors == 0 && board.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, board.pending.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

/* minimap_point_projector.f */
src/mmp_pkg.sv
src/mmp_obj_if.sv
src/mmp_pix_if.sv
src/mmp_rotate.sv
src/mmp_clamp.sv
src/mmp_project.sv
src/minimap_point_projector.sv
verif/minimap_point_projector_test.sv
